>>> rtl/frame_slot_ring_manager_macros.svh
// Assertion macros used by the frame slot ring manager core.
`ifndef FRAME_SLOT_RING_MANAGER_MACROS_SVH
`define FRAME_SLOT_RING_MANAGER_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define FSRM_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define FSRM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/fsrm_pkg.sv
// Types, constants and codes shared by the frame slot ring manager.
package fsrm_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);

  localparam int CMD_W     = 2;
  localparam int TAG_W     = 32;
  localparam int BYTES_W   = 25;
  localparam int REL_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int IDX_W     = 4;
  localparam int ADDR_W    = 28;
  localparam int FREE_W    = 5;

  localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = BYTES_W'(1048576);

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE = 2'd0,
    CMD_FETCH   = 2'd1,
    CMD_RELEASE = 2'd2
  } fsrm_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 3'd0,
    STS_FULL       = 3'd1,
    STS_TOO_LARGE  = 3'd2,
    STS_EMPTY      = 3'd3,
    STS_RANGE      = 3'd4,
    STS_REL_FREE   = 3'd5,
    STS_FETCH_FREE = 3'd6
  } fsrm_status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsrm_state_t;

  // One queued frame
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
    logic [SLOT_W-1:0]  slot;
  } fsrm_entry_t;

  // Result of one command, before address scaling
  typedef struct packed {
    logic               valid;
    fsrm_status_t       status;
    logic [SLOT_W-1:0]  slot;
    logic               addr_en;
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
    logic [COUNT_W-1:0] free_count;
    logic               all_free;
  } fsrm_result_t;

endpackage

>>> rtl/fsrm_queue_ram.sv
// Pending frame queue storage: one write port, one registered read port.
module fsrm_queue_ram (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [fsrm_pkg::SLOT_W-1:0]             wr_addr,
  input  fsrm_pkg::fsrm_entry_t                   wr_data,
  input  logic                                    rd_en,
  input  logic [fsrm_pkg::SLOT_W-1:0]             rd_addr,
  output fsrm_pkg::fsrm_entry_t                   rd_data
);
  import fsrm_pkg::*;

  fsrm_entry_t mem [NUM_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/fsrm_core.sv
// Command sequencer: slot ownership, ring pointer and queue bookkeeping.
`include "frame_slot_ring_manager_macros.svh"

module fsrm_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [fsrm_pkg::CMD_W-1:0]        command,
  input  logic [fsrm_pkg::TAG_W-1:0]        frame_tag,
  input  logic [fsrm_pkg::BYTES_W-1:0]      frame_bytes,
  input  logic [fsrm_pkg::REL_W-1:0]        release_slot,
  input  logic [fsrm_pkg::BYTES_W-1:0]      slot_bytes,
  output logic                              busy,
  output fsrm_pkg::fsrm_result_t            res
);
  import fsrm_pkg::*;

  fsrm_state_t        state, state_next;
  logic [NUM_SLOTS-1:0] slot_held, slot_held_next;
  logic [SLOT_W-1:0]  next_slot, next_slot_next;
  logic [COUNT_W-1:0] held_count, held_count_next;
  logic [SLOT_W-1:0]  q_head, q_head_next;
  logic [SLOT_W-1:0]  q_tail, q_tail_next;
  logic [COUNT_W-1:0] q_count, q_count_next;

  // command captured at accept
  logic [CMD_W-1:0]   cmd_q;
  logic [TAG_W-1:0]   tag_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [REL_W-1:0]   rel_q;

  logic               accept;
  logic               wr_en;
  fsrm_entry_t        wr_data;
  fsrm_entry_t        rd_data;

  assign accept = start && (state == FSM_IDLE);
  assign busy   = (state == FSM_EXEC);

  // head entry is read at accept so it is ready during execute
  fsrm_queue_ram u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_tail),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (q_head),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      slot_held  <= '0;
      next_slot  <= '0;
      held_count <= '0;
      q_head     <= '0;
      q_tail     <= '0;
      q_count    <= '0;
    end else begin
      state      <= state_next;
      slot_held  <= slot_held_next;
      next_slot  <= next_slot_next;
      held_count <= held_count_next;
      q_head     <= q_head_next;
      q_tail     <= q_tail_next;
      q_count    <= q_count_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      tag_q   <= frame_tag;
      bytes_q <= frame_bytes;
      rel_q   <= release_slot;
    end
  end

  // next state and command execution
  always_comb begin
    state_next      = state;
    slot_held_next  = slot_held;
    next_slot_next  = next_slot;
    held_count_next = held_count;
    q_head_next     = q_head;
    q_tail_next     = q_tail;
    q_count_next    = q_count;
    wr_en           = 1'b0;
    wr_data.tag     = tag_q;
    wr_data.bytes   = bytes_q;
    wr_data.slot    = next_slot;
    res             = '0;
    res.status      = STS_OK;

    case (state)
      FSM_IDLE: begin
        if (start) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_next = FSM_IDLE;
        res.valid  = 1'b1;
        case (cmd_q)
          CMD_RESERVE: begin
            if (bytes_q > slot_bytes) begin
              res.status = STS_TOO_LARGE;
            end else if (slot_held[next_slot] ||
                         (q_count == COUNT_W'(NUM_SLOTS))) begin
              res.status = STS_FULL;
            end else begin
              slot_held_next[next_slot] = 1'b1;
              held_count_next = held_count + 1'b1;
              next_slot_next  = (next_slot == SLOT_W'(NUM_SLOTS - 1)) ?
                                '0 : next_slot + 1'b1;
              wr_en           = 1'b1;
              q_tail_next     = (q_tail == SLOT_W'(NUM_SLOTS - 1)) ?
                                '0 : q_tail + 1'b1;
              q_count_next    = q_count + 1'b1;
              res.slot        = next_slot;
              res.addr_en     = 1'b1;
            end
          end
          CMD_FETCH: begin
            if (q_count == '0) begin
              res.status = STS_EMPTY;
            end else begin
              q_head_next  = (q_head == SLOT_W'(NUM_SLOTS - 1)) ?
                             '0 : q_head + 1'b1;
              q_count_next = q_count - 1'b1;
              res.slot     = rd_data.slot;
              res.tag      = rd_data.tag;
              res.bytes    = rd_data.bytes;
              if (!slot_held[rd_data.slot]) begin
                res.status = STS_FETCH_FREE;
              end else begin
                res.addr_en = 1'b1;
              end
            end
          end
          CMD_RELEASE: begin
            if ({1'b0, rel_q} >= (REL_W + 1)'(NUM_SLOTS)) begin
              res.status = STS_RANGE;
            end else if (!slot_held[rel_q[SLOT_W-1:0]]) begin
              res.status = STS_REL_FREE;
            end else begin
              slot_held_next[rel_q[SLOT_W-1:0]] = 1'b0;
              held_count_next = held_count - 1'b1;
            end
          end
          default: begin
            res.status = STS_OK;
          end
        endcase
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase

    // occupancy after the command
    res.free_count = COUNT_W'(NUM_SLOTS) - held_count_next;
    res.all_free   = (held_count_next == '0);
  end

  `FSRM_ASSERT_NOW(a_held_count, 1'b1, $countones(slot_held) == int'(held_count), "held count off")
  `FSRM_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= COUNT_W'(NUM_SLOTS), "queue overfull")
  `FSRM_ASSERT_NOW(a_write_in_exec, wr_en, state == FSM_EXEC, "queue write outside execute")
  `FSRM_ASSERT_NEXT(a_exec_one_cycle, state == FSM_EXEC, state == FSM_IDLE, "execute overran")

endmodule

>>> rtl/frame_slot_ring_manager.sv
// Top level: configuration register, command core and result register.
//
// Frame slot ring manager. A command (reserve, fetch, release) is taken on a
// clk edge with start high and busy low. busy is then high for one cycle while
// the command executes against the pending frame queue, and its result is
// presented on the following cycle with done high for exactly one cycle; the
// receiver cannot stall, so it must capture the result beat when done is set.
// A command executes after accept because the queue memory read is registered;
// a new command may be started in the cycle that done is high.
// slot_bytes is written through cfg_valid/cfg_data (cfg_ready is always high)
// and must only be changed while no command is in flight.
module frame_slot_ring_manager (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fsrm_pkg::CMD_W-1:0]        command,
  input  logic [fsrm_pkg::TAG_W-1:0]        frame_tag,
  input  logic [fsrm_pkg::BYTES_W-1:0]      frame_bytes,
  input  logic [fsrm_pkg::REL_W-1:0]        release_slot,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fsrm_pkg::BYTES_W-1:0]      cfg_data,
  output logic                              done,
  output logic [fsrm_pkg::STATUS_W-1:0]     status,
  output logic [fsrm_pkg::IDX_W-1:0]        slot_index,
  output logic [fsrm_pkg::ADDR_W-1:0]       slot_address,
  output logic [fsrm_pkg::TAG_W-1:0]        out_tag,
  output logic [fsrm_pkg::BYTES_W-1:0]      out_bytes,
  output logic [fsrm_pkg::FREE_W-1:0]       free_count,
  output logic                              all_free
);
  import fsrm_pkg::*;

  localparam int PROD_W = SLOT_W + BYTES_W;

  logic [BYTES_W-1:0] slot_bytes;
  fsrm_result_t       res;
  logic [PROD_W-1:0]  prod;

  assign cfg_ready = 1'b1;

  // slot size register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bytes <= SLOT_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_bytes <= cfg_data;
    end
  end

  fsrm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .frame_tag    (frame_tag),
    .frame_bytes  (frame_bytes),
    .release_slot (release_slot),
    .slot_bytes   (slot_bytes),
    .busy         (busy),
    .res          (res)
  );

  // slot byte offset
  assign prod = PROD_W'(res.slot) * PROD_W'(slot_bytes);

  // result beat strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      status       <= res.status;
      slot_index   <= IDX_W'(res.slot);
      slot_address <= res.addr_en ? ADDR_W'(prod) : '0;
      out_tag      <= res.tag;
      out_bytes    <= res.bytes;
      free_count   <= FREE_W'(res.free_count);
      all_free     <= res.all_free;
    end
  end

endmodule
